/* hw/rtl/fwrm_pkg.sv */
// shared types and codes for the fifo with running maximum
`default_nettype none

package fwrm_pkg;

    localparam int DATA_W  = 32;
    localparam int OP_W    = 2;
    localparam int ST_W    = 2;
    localparam int LIMIT_W = 6;
    localparam int OSEL_W  = 2;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [OP_W-1:0]          t_op;
    typedef logic [ST_W-1:0]          t_status;
    typedef logic [LIMIT_W-1:0]       t_limit;
    typedef logic [OSEL_W-1:0]        t_osel;

    // operation codes
    localparam t_op OP_ENQ   = 2'd0;
    localparam t_op OP_DEQ   = 2'd1;
    localparam t_op OP_MAX   = 2'd2;
    localparam t_op OP_DRAIN = 2'd3;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_FULL  = 2'd1;
    localparam t_status ST_EMPTY = 2'd2;

    // output data source
    localparam t_osel OSEL_PEND = 2'd0;
    localparam t_osel OSEL_RAM  = 2'd1;
    localparam t_osel OSEL_BEST = 2'd2;

    localparam t_limit LIMIT_RESET = 6'd32;

    typedef struct packed {
        logic    wr_en;
        logic    pop;
        logic    clear;
        logic    rd_first;
        logic    rd_next;
        logic    max_acc;
        logic    set_pend;
        t_status pend_status;
        logic    out_load;
        t_osel   out_sel;
        logic    out_last;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
        logic idx_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

/* hw/rtl/fwrm_if.sv */
// request, result and register-write channel interfaces
`default_nettype none

interface fwrm_in_if;
    logic             valid;
    logic             ready;
    fwrm_pkg::t_op    operation;
    fwrm_pkg::t_word  value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface fwrm_out_if;
    logic              valid;
    logic              ready;
    fwrm_pkg::t_word   data;
    fwrm_pkg::t_status status;
    logic              last;

    modport source (output valid, output data, output status, output last, input ready);
    modport sink   (input valid, input data, input status, input last, output ready);
endinterface

interface fwrm_cfg_if;
    logic             valid;
    logic             ready;
    fwrm_pkg::t_limit queue_limit;

    modport source (output valid, output queue_limit, input ready);
    modport sink   (input valid, input queue_limit, output ready);
endinterface

`default_nettype wire

/* hw/rtl/fwrm_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module fwrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic                                    i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fwrm_ctrl.sv */
// controller state machine for the fifo with running maximum
`default_nettype none

module fwrm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    input  wire fwrm_pkg::t_op    i_operation,
    output logic                  o_in_ready,
    input  wire fwrm_pkg::t_stat  i_stat,
    output fwrm_pkg::t_cmd        o_cmd
);
    import fwrm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RESP = 3'd1;
    localparam logic [2:0] S_DEQ  = 3'd2;
    localparam logic [2:0] S_MAXW = 3'd3;
    localparam logic [2:0] S_MAXO = 3'd4;
    localparam logic [2:0] S_DRN  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_operation == OP_ENQ) begin
                        o_cmd.wr_en       = !i_stat.full;
                        o_cmd.set_pend    = 1'b1;
                        o_cmd.pend_status = i_stat.full ? ST_FULL : ST_OK;
                        n_state           = S_RESP;
                    end else if (i_stat.empty) begin
                        o_cmd.set_pend    = 1'b1;
                        o_cmd.pend_status = ST_EMPTY;
                        n_state           = S_RESP;
                    end else begin
                        o_cmd.rd_first = 1'b1;
                        case (i_operation)
                            OP_DEQ: begin
                                o_cmd.pop = 1'b1;
                                n_state   = S_DEQ;
                            end
                            OP_MAX: begin
                                n_state = S_MAXW;
                            end
                            default: begin
                                n_state = S_DRN;
                            end
                        endcase
                    end
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_PEND;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DEQ: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_RAM;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_MAXW: begin
                o_cmd.max_acc = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_MAXO;
                end else begin
                    o_cmd.rd_next = 1'b1;
                end
            end
            S_MAXO: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_BEST;
                    o_cmd.out_last = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DRN: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = OSEL_RAM;
                    o_cmd.out_last = i_stat.idx_last;
                    if (i_stat.idx_last) begin
                        o_cmd.clear = 1'b1;
                        n_state     = S_IDLE;
                    end else begin
                        o_cmd.rd_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fwrm_dpath.sv */
// datapath: entry ram, head and count, limit register, max accumulator, output register
`default_nettype none

module fwrm_dpath #(
    parameter int CAPACITY = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fwrm_pkg::t_word    i_value,
    input  wire logic               i_cfg_valid,
    input  wire fwrm_pkg::t_limit   i_cfg_limit,
    output logic                    o_cfg_ready,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output fwrm_pkg::t_word         o_out_data,
    output fwrm_pkg::t_status       o_out_status,
    output logic                    o_out_last,
    input  wire fwrm_pkg::t_cmd     i_cmd,
    output fwrm_pkg::t_stat         o_stat
);
    import fwrm_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam logic [AW:0]   CAP_S = (AW + 1)'(CAPACITY);
    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
    localparam logic [AW-1:0] LAST_SLOT = AW'(CAPACITY - 1);

    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    t_limit        r_limit;
    logic [AW-1:0] r_idx;
    t_word         r_best;
    t_status       r_pend_status;

    logic [AW-1:0] idx_nxt;
    logic [AW:0]   wsum;
    logic [AW:0]   rsum;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [LW-1:0] limit_ext;
    logic [LW-1:0] eff_limit;
    logic          rd_en;
    logic          out_free;
    t_word         ram_rdata;

    // circular slot of head plus offset, offset below capacity
    assign idx_nxt = r_idx + AW'(1);
    assign wsum    = {1'b0, r_head} + {1'b0, r_count[AW-1:0]};
    assign rsum    = {1'b0, r_head} + {1'b0, idx_nxt};
    assign waddr   = (wsum >= CAP_S) ? AW'(wsum - CAP_S) : wsum[AW-1:0];
    assign raddr   = i_cmd.rd_first ? r_head
                   : ((rsum >= CAP_S) ? AW'(rsum - CAP_S) : rsum[AW-1:0]);
    assign rd_en   = i_cmd.rd_first | i_cmd.rd_next;

    fwrm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // limit above capacity acts as capacity
    assign limit_ext = LW'(r_limit);
    assign eff_limit = (limit_ext > CAP_L) ? CAP_L : limit_ext;

    assign out_free        = !o_out_valid || i_out_ready;
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.full     = (LW'(r_count) >= eff_limit);
    assign o_stat.idx_last = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_stat.out_free = out_free;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
            r_limit <= LIMIT_RESET;
            r_idx   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_limit;
            end
            if (i_cmd.clear) begin
                r_head  <= '0;
                r_count <= '0;
            end else if (i_cmd.wr_en) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop) begin
                r_count <= r_count - CW'(1);
                r_head  <= (r_head == LAST_SLOT) ? '0 : r_head + AW'(1);
            end
            if (i_cmd.rd_first) begin
                r_idx <= '0;
            end else if (i_cmd.rd_next) begin
                r_idx <= idx_nxt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_pend) begin
            r_pend_status <= i_cmd.pend_status;
        end
        if (i_cmd.max_acc) begin
            if (r_idx == '0 || ram_rdata > r_best) begin
                r_best <= ram_rdata;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_last <= i_cmd.out_last;
            case (i_cmd.out_sel)
                OSEL_RAM: begin
                    o_out_data   <= ram_rdata;
                    o_out_status <= ST_OK;
                end
                OSEL_BEST: begin
                    o_out_data   <= r_best;
                    o_out_status <= ST_OK;
                end
                default: begin
                    o_out_data   <= '0;
                    o_out_status <= r_pend_status;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/fifo_with_running_max.sv */
// top level of the bounded fifo with running maximum
//
//   channel  dir  fields                      handshake
//   i_in     in   operation, value            valid / ready
//   o_out    out  data, status, last          valid / ready
//   i_cfg    in   queue_limit                 valid / ready (ready always high)
//
// enqueue, dequeue and any request on an empty queue are accepted in idle and answered from one response step
// max query reads the ram one entry per cycle, then loads the largest entry into o_out
// drain reads the entries in order, one result per cycle while o_out is not stalled
// reset clears head, count and control; queue_limit resets to 32; ram is not cleared
// a stalled o_out holds the controller in any step that loads a result, the ram read data holds too
`default_nettype none

module fifo_with_running_max #(
    parameter int CAPACITY = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    fwrm_in_if.sink   i_in,
    fwrm_out_if.source o_out,
    fwrm_cfg_if.sink  i_cfg
);
    import fwrm_pkg::*;

    // command and status between controller and datapath
    t_cmd  cmd;
    t_stat stat;

    // controller: sequences one request at a time
    fwrm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_operation (i_in.operation),
        .o_in_ready  (i_in.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // datapath: storage, pointers, limit, max walk and result register
    fwrm_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_value      (i_in.value),
        .i_cfg_valid  (i_cfg.valid),
        .i_cfg_limit  (i_cfg.queue_limit),
        .o_cfg_ready  (i_cfg.ready),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_data   (o_out.data),
        .o_out_status (o_out.status),
        .o_out_last   (o_out.last),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

endmodule

`default_nettype wire

/* hw/rtl/fwrm_checker.sv */
// port-level checks for the fifo with running maximum, bound to the top level
`default_nettype none

module fwrm_checker (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire fwrm_pkg::t_word   i_out_data,
    input wire fwrm_pkg::t_status i_out_status,
    input wire logic              i_out_last
);
    import fwrm_pkg::*;

    // a held result stays put until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data)
            && $stable(i_out_status) && $stable(i_out_last))
        else $error("result changed while stalled");

    // reset empties the result register
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // full or empty reports carry zero data and close the request
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_status != ST_OK |-> i_out_data == '0 && i_out_last)
        else $error("error result with data or without last");

    // one request at a time: an accepted request blocks the next cycle
    a_one_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request accepted back to back");

endmodule

bind fifo_with_running_max fwrm_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_data   (o_out.data),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last)
);

`default_nettype wire

/* test/tb_fifo_with_running_max.sv */
// self-checking testbench for the bounded fifo with running maximum
module tb_fifo_with_running_max;
    import fwrm_pkg::*;

    localparam int DEPTH          = 32;
    // idle cycles after the last result before a register write or the verdict
    localparam int SETTLE_CYCLES  = 40;
    localparam int PHASE_REQUESTS = 10;
    localparam int MAX_REPORTS    = 40;

    localparam t_op ALL_OPS [4] = '{OP_ENQ, OP_DEQ, OP_MAX, OP_DRAIN};
    // limit settings per phase: both extremes, below, at and above capacity
    localparam t_limit LIMIT_PLAN [8] = '{6'd0, 6'd1, 6'd63, 6'd5, 6'd33, 6'd17, 6'd2, 6'd32};

    typedef struct packed {
        t_word   data;
        t_status status;
        logic    last;
    } q_result_t;

    // shadow of the queue contents plus the results still owed by the block
    class max_queue_board;
        t_word       held [DEPTH];
        int unsigned head;
        int unsigned count;
        t_limit      limit;
        q_result_t   owed [$];
        int unsigned errors;
        int unsigned seen;

        function new();
            head   = 0;
            count  = 0;
            limit  = LIMIT_RESET;
            errors = 0;
            seen   = 0;
        endfunction

        // a limit above capacity behaves as capacity
        function int unsigned room();
            return (limit > DEPTH) ? DEPTH : limit;
        endfunction

        function void set_limit(t_limit lim);
            limit = lim;
        endfunction

        function int unsigned pending();
            return owed.size();
        endfunction

        function void owe(t_word d, t_status s, logic l);
            q_result_t r;
            r.data   = d;
            r.status = s;
            r.last   = l;
            owed.push_back(r);
        endfunction

        // called once per accepted request
        function void note_request(t_op op, t_word v);
            t_word best;
            if (op == OP_ENQ) begin
                if (count >= room()) begin
                    owe('0, ST_FULL, 1'b1);
                end else begin
                    held[(head + count) % DEPTH] = v;
                    count++;
                    owe('0, ST_OK, 1'b1);
                end
            end else if (count == 0) begin
                owe('0, ST_EMPTY, 1'b1);
            end else if (op == OP_DEQ) begin
                owe(held[head], ST_OK, 1'b1);
                head = (head + 1) % DEPTH;
                count--;
            end else if (op == OP_MAX) begin
                best = held[head];
                for (int i = 1; i < count; i++) begin
                    if (held[(head + i) % DEPTH] > best) best = held[(head + i) % DEPTH];
                end
                owe(best, ST_OK, 1'b1);
            end else begin
                for (int i = 0; i < count; i++) begin
                    owe(held[(head + i) % DEPTH], ST_OK, (i + 1 == count));
                end
                head  = 0;
                count = 0;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS) $display("mismatch: %s", msg);
        endtask

        task check_result(t_word d, t_status s, logic l);
            q_result_t want;
            seen++;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("result %0d not owed: data %0d status %0d last %0b",
                                          seen, d, s, l));
            end else begin
                want = owed.pop_front();
                if (d !== want.data)
                    report_mismatch($sformatf("result %0d data %0d, want %0d",
                                              seen, d, want.data));
                if (s !== want.status)
                    report_mismatch($sformatf("result %0d status %0d, want %0d",
                                              seen, s, want.status));
                if (l !== want.last)
                    report_mismatch($sformatf("result %0d last %0b, want %0b",
                                              seen, l, want.last));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    fwrm_in_if  in_ch ();
    fwrm_out_if out_ch ();
    fwrm_cfg_if cfg_ch ();

    max_queue_board board = new();

    // idle_en switches idling per phase, tail_quiet turns it off for the last phase
    bit idle_en    = 1'b1;
    bit tail_quiet = 1'b0;

    fifo_with_running_max #(
        .CAPACITY(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source),
        .i_cfg  (cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: stalls come in random bursts
    initial begin
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_left != 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_en && !tail_quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 9);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // every accepted result is checked against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            board.check_result(out_ch.data, out_ch.status, out_ch.last);
        end
    end

    // mostly full-range words, with corners and a small band around zero for ties
    function automatic t_word pick_value();
        t_word corner [4] = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1};
        case ($urandom_range(0, 4))
            0: begin
                return corner[$urandom_range(0, 3)];
            end
            1: begin
                return t_word'($urandom_range(0, 20)) - t_word'(10);
            end
            default: begin
                return t_word'($urandom());
            end
        endcase
    endfunction

    function automatic t_op pick_op();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40) return OP_ENQ;
        if (r < 65) return OP_DEQ;
        if (r < 90) return OP_MAX;
        return OP_DRAIN;
    endfunction

    // one request; valid stays high into the next request unless a gap is taken
    task automatic send_request(input t_op op, input t_word v);
        int unsigned gap;
        if (idle_en && !tail_quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 10);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.operation <= op;
        in_ch.value     <= v;
        do @(posedge i_clk); while (!in_ch.ready);
        board.note_request(op, v);
    endtask

    // hold off requests until every owed result has come, then let the block settle
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input t_limit lim);
        wait_quiet();
        cfg_ch.valid       <= 1'b1;
        cfg_ch.queue_limit <= lim;
        do @(posedge i_clk); while (!cfg_ch.ready);
        board.set_limit(lim);
        cfg_ch.valid <= 1'b0;
    endtask

    // fill to the limit with a few max queries mixed in, run into full once or
    // twice, then empty by a drain or shrink by dequeues up to one past empty
    task automatic fill_and_empty(input bit use_drain, inout int unsigned sent);
        int unsigned extra;
        int unsigned n;
        extra = $urandom_range(1, 2);
        while (extra != 0) begin
            if ($urandom_range(0, 7) == 0) begin
                send_request(OP_MAX, pick_value());
            end else begin
                if (board.count >= board.room()) extra--;
                send_request(OP_ENQ, pick_value());
            end
            sent++;
        end
        if (use_drain) begin
            send_request(OP_DRAIN, pick_value());
            sent++;
        end else begin
            n = $urandom_range(1, board.count + 1);
            repeat (n) begin
                send_request(OP_DEQ, pick_value());
                sent++;
            end
        end
    endtask

    task automatic run_phase(input int unsigned quota);
        int unsigned sent;
        int unsigned n;
        sent = 0;
        while (sent < quota) begin
            case ($urandom_range(0, 3))
                0, 1: begin
                    fill_and_empty($urandom_range(0, 2) != 0, sent);
                end
                2: begin
                    // mixed traffic, enqueue-heavy so the queue keeps some depth
                    n = $urandom_range(5, 20);
                    repeat (n) begin
                        send_request(pick_op(), pick_value());
                        sent++;
                    end
                end
                default: begin
                    // short noise burst, any operation with any value
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_request(ALL_OPS[$urandom_range(0, 3)], t_word'($urandom()));
                        sent++;
                    end
                end
            endcase
        end
    endtask

    initial begin
        int unsigned spare;
        spare = 0;
        i_rst_n            <= 1'b0;
        in_ch.valid        <= 1'b0;
        in_ch.operation    <= OP_ENQ;
        in_ch.value        <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.queue_limit <= LIMIT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset limit
        // every non-enqueue operation on an empty queue
        send_request(OP_DEQ, 32'sh0000_1234);
        send_request(OP_MAX, -32'sh1);
        send_request(OP_DRAIN, 32'sh7fff_ffff);
        // signed extremes: the most negative word alone, then as the oldest entry
        send_request(OP_ENQ, 32'sh8000_0000);
        send_request(OP_MAX, 32'sh0);
        send_request(OP_ENQ, 32'sh7fff_ffff);
        send_request(OP_ENQ, -32'sh1);
        send_request(OP_ENQ, 32'sh0);
        send_request(OP_MAX, 32'sh0);
        send_request(OP_DEQ, 32'sh0);
        send_request(OP_MAX, 32'sh0);
        send_request(OP_DEQ, 32'sh0);
        // max among -1 and 0, then equal values held twice
        send_request(OP_MAX, 32'sh0);
        send_request(OP_ENQ, -32'sh5);
        send_request(OP_ENQ, -32'sh5);
        send_request(OP_DRAIN, 32'sh0);
        send_request(OP_DRAIN, 32'sh0);
        send_request(OP_ENQ, 32'sh1);
        send_request(OP_DEQ, 32'sh0);
        send_request(OP_DEQ, 32'sh0);
        // drain of a single entry carries last on its only result
        send_request(OP_ENQ, 32'sh7b);
        send_request(OP_DRAIN, 32'sh0);

        // random part, one phase per limit setting; each write waits for an empty pipe
        foreach (LIMIT_PLAN[p]) begin
            write_limit(LIMIT_PLAN[p]);
            tail_quiet = (p == $size(LIMIT_PLAN) - 1);
            idle_en    = ($urandom_range(0, 3) != 0);
            // the last phase always drains a queue filled to capacity
            if (tail_quiet) fill_and_empty(1'b1, spare);
            run_phase(PHASE_REQUESTS);
        end

        wait_quiet();
        if (board.errors == 0 && board.pending() == 0) begin
            $display("fifo_with_running_max test passed");
        end else begin
            $display("fifo_with_running_max test failed");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #6_000_000;
        $display("fifo_with_running_max test failed");
        $finish;
    end

endmodule

/* fifo_with_running_max.f */
hw/rtl/fwrm_pkg.sv
hw/rtl/fwrm_if.sv
hw/rtl/fwrm_ram.sv
hw/rtl/fwrm_ctrl.sv
hw/rtl/fwrm_dpath.sv
hw/rtl/fifo_with_running_max.sv
hw/rtl/fwrm_checker.sv
test/tb_fifo_with_running_max.sv
